// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the hash RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during rst.
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet during rst.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sha1sh_pkg.sv =====
// Types and constants for the streaming SHA-1 hash block.
package sha1sh_pkg;

  localparam int CHAIN_WORDS = 5;
  localparam int BLOCK_WORDS = 16;
  localparam int ADDR_W      = 4;

  localparam logic [2:0] LAST_WORD = 3'd4;

  // Core cycle counter: fetch 0..15, rounds on 1..80, chaining add on 81.
  localparam logic [6:0] CYC_FETCH_END = 7'd16;
  localparam logic [6:0] CYC_LAST_LOAD = 7'd16;
  localparam logic [6:0] CYC_K0_END    = 7'd20;
  localparam logic [6:0] CYC_K1_END    = 7'd40;
  localparam logic [6:0] CYC_K2_END    = 7'd60;
  localparam logic [6:0] CYC_DONE      = 7'd81;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  typedef logic [CHAIN_WORDS-1:0][31:0] chain_t;

  localparam chain_t IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                           32'hEFCDAB89, 32'h67452301};

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       end_of_message;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
  } digest_t;

  typedef struct packed {
    logic start;
    logic iv_load;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

endpackage

// ===== hdl/sha1sh_msg_ram.sv =====
// Message block store: 16 x 32-bit words, one write and one registered read port.
module sha1sh_msg_ram (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [sha1sh_pkg::ADDR_W-1:0]  wr_addr,
  input  logic [31:0]                    wr_data,
  input  logic                           rd_en,
  input  logic [sha1sh_pkg::ADDR_W-1:0]  rd_addr,
  output logic [31:0]                    rd_data
);

  logic [31:0] mem [sha1sh_pkg::BLOCK_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/sha1sh_core.sv =====
// SHA-1 compression: fetches the block from the store, runs 80 rounds, adds into the chain.
`include "assert_macros.svh"

module sha1sh_core (
  input  logic                           clk,
  input  logic                           rst,
  input  sha1sh_pkg::core_ctl_t          ctl,
  output sha1sh_pkg::core_sts_t          sts,
  output logic                           rd_en,
  output logic [sha1sh_pkg::ADDR_W-1:0]  rd_addr,
  input  logic [31:0]                    rd_data,
  output sha1sh_pkg::chain_t             chain
);

  logic        busy;
  logic [6:0]  cyc;
  logic [31:0] a, b, c, d, e;
  logic [31:0] w [sha1sh_pkg::BLOCK_WORDS];

  logic [31:0] f, k, x, sched, tmp;
  logic        round_en, done;

  assign rd_en   = busy && (cyc < sha1sh_pkg::CYC_FETCH_END);
  assign rd_addr = cyc[sha1sh_pkg::ADDR_W-1:0];

  assign round_en = busy && (cyc != 7'd0) && (cyc != sha1sh_pkg::CYC_DONE);
  assign done     = busy && (cyc == sha1sh_pkg::CYC_DONE);

  assign sts.busy = busy;
  assign sts.done = done;

  // w[15] is the newest schedule word, w[0] the one sixteen rounds back
  always_comb begin
    sched = w[13] ^ w[8] ^ w[2] ^ w[0];
    if (cyc <= sha1sh_pkg::CYC_LAST_LOAD) begin
      x = rd_data;
    end else begin
      x = {sched[30:0], sched[31]};
    end
    if (cyc <= sha1sh_pkg::CYC_K0_END) begin
      f = (b & c) | (~b & d);
      k = sha1sh_pkg::K0;
    end else if (cyc <= sha1sh_pkg::CYC_K1_END) begin
      f = b ^ c ^ d;
      k = sha1sh_pkg::K1;
    end else if (cyc <= sha1sh_pkg::CYC_K2_END) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1sh_pkg::K2;
    end else begin
      f = b ^ c ^ d;
      k = sha1sh_pkg::K3;
    end
    tmp = {a[26:0], a[31:27]} + f + e + k + x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cyc  <= 7'd0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cyc  <= 7'd0;
    end else if (busy) begin
      cyc <= cyc + 7'd1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (round_en) begin
      a <= tmp;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (round_en) begin
      for (int i = 0; i < sha1sh_pkg::BLOCK_WORDS - 1; i++) begin
        w[i] <= w[i+1];
      end
      w[sha1sh_pkg::BLOCK_WORDS-1] <= x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.iv_load) begin
      chain <= sha1sh_pkg::IV;
    end else if (done) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
      chain[4] <= chain[4] + e;
    end
  end

  `CHK_IMPL(a_start_idle, ctl.start, !busy, "compression started while busy")
  `CHK_NEXT(a_start_runs, ctl.start, busy && (cyc == 7'd0), "start did not launch a run")

endmodule

// ===== hdl/sha1_stream_hash.sv =====
// Streaming SHA-1 top level: byte packing, padding, compression control, digest output.
// Message bytes go in at 1 byte a cycle, held off while each block's compression runs
// (16-word fetch from the block store overlapped with 80 rounds, plus the chaining add).
// Close: padding goes in at 1 byte a cycle with the same compressions, then the five
// digest words leave through an output register, one per cycle when taken.
// Reset clears control and loads the IV; the block store is not cleared.
`include "assert_macros.svh"

module sha1_stream_hash (
  input  logic                clk,
  input  logic                rst,
  input  sha1sh_pkg::msg_t    msg,
  input  logic                msg_valid,
  output logic                msg_ready,
  output sha1sh_pkg::digest_t digest,
  output logic                digest_valid,
  input  logic                digest_ready
);

  localparam logic [1:0] S_IN   = 2'd0;
  localparam logic [1:0] S_PAD  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [1:0] PH_MARK = 2'd0;
  localparam logic [1:0] PH_ZERO = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;

  logic [1:0]  state;
  logic [1:0]  ret_state;
  logic [1:0]  ph;
  logic [5:0]  pos;
  logic [63:0] bit_length;
  logic [63:0] len_snap;
  logic [23:0] pack;
  logic [2:0]  idx;

  logic        accept, put_en, sel_len, load;
  logic [7:0]  put_byte;
  logic [7:0]  len_byte;
  logic [7:0][7:0] len_bytes;

  logic                          wr_en;
  logic [sha1sh_pkg::ADDR_W-1:0] wr_addr;
  logic [31:0]                   wr_data;
  logic                          rd_en;
  logic [sha1sh_pkg::ADDR_W-1:0] rd_addr;
  logic [31:0]                   rd_data;

  sha1sh_pkg::core_ctl_t core_ctl;
  sha1sh_pkg::core_sts_t core_sts;
  sha1sh_pkg::chain_t    chain;

  assign msg_ready = (state == S_IN);
  assign accept    = msg_valid && msg_ready;

  // length goes out big-endian: byte 0 of the trailer is bits 63:56
  assign len_bytes = len_snap;
  assign len_byte  = len_bytes[~pos[2:0]];
  assign sel_len   = (ph == PH_LEN) || ((ph == PH_ZERO) && (pos == sha1sh_pkg::LEN_POS));

  always_comb begin
    put_en   = 1'b0;
    put_byte = 8'h00;
    unique case (state)
      S_IN: begin
        put_en   = accept && msg.byte_valid;
        put_byte = msg.msg_byte;
      end
      S_PAD: begin
        put_en = 1'b1;
        if (ph == PH_MARK) begin
          put_byte = sha1sh_pkg::PAD_MARK;
        end else if (sel_len) begin
          put_byte = len_byte;
        end
      end
      default: begin
      end
    endcase
  end

  assign wr_en   = put_en && (pos[1:0] == 2'b11);
  assign wr_addr = pos[5:2];
  assign wr_data = {pack, put_byte};

  assign load = (state == S_OUT) && (!digest_valid || digest_ready);

  assign core_ctl.start   = put_en && (pos == sha1sh_pkg::LAST_POS);
  assign core_ctl.iv_load = load && (idx == sha1sh_pkg::LAST_WORD);

  always_ff @(posedge clk) begin
    if (put_en) begin
      pack <= {pack[15:0], put_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IN;
      ret_state  <= S_IN;
      ph         <= PH_MARK;
      pos        <= 6'd0;
      bit_length <= 64'd0;
      idx        <= 3'd0;
    end else begin
      if (put_en) begin
        pos <= pos + 6'd1;
      end
      unique case (state)
        S_IN: begin
          if (accept) begin
            if (msg.byte_valid) begin
              bit_length <= bit_length + 64'd8;
            end
            if (msg.end_of_message) begin
              len_snap   <= bit_length + (msg.byte_valid ? 64'd8 : 64'd0);
              bit_length <= 64'd0;
              ph         <= PH_MARK;
            end
            if (core_ctl.start) begin
              state     <= S_WAIT;
              ret_state <= msg.end_of_message ? S_PAD : S_IN;
            end else if (msg.end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (ph == PH_MARK) begin
            ph <= PH_ZERO;
          end else if (sel_len) begin
            ph <= PH_LEN;
          end
          if (core_ctl.start) begin
            state     <= S_WAIT;
            ret_state <= sel_len ? S_OUT : S_PAD;
          end
        end
        S_WAIT: begin
          if (core_sts.done) begin
            state <= ret_state;
            idx   <= 3'd0;
          end
        end
        S_OUT: begin
          if (load) begin
            idx <= idx + 3'd1;
            if (idx == sha1sh_pkg::LAST_WORD) begin
              state <= S_IN;
            end
          end
        end
        default: begin
          state <= S_IN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digest_valid <= 1'b0;
    end else if (load) begin
      digest_valid <= 1'b1;
    end else if (digest_ready) begin
      digest_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digest.digest_word <= chain[idx];
      digest.word_index  <= idx;
      digest.digest_last <= (idx == sha1sh_pkg::LAST_WORD);
    end
  end

  sha1sh_msg_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sha1sh_core u_core (
    .clk     (clk),
    .rst     (rst),
    .ctl     (core_ctl),
    .sts     (core_sts),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .chain   (chain)
  );

  `CHK_NEXT(a_close_leaves_in, accept && msg.end_of_message, state != S_IN,
            "close word did not leave input state")
  `CHK_IMPL(a_last_index, digest_valid && digest.digest_last,
            digest.word_index == sha1sh_pkg::LAST_WORD, "last flag on wrong word")
  `CHK_IMPL(a_no_write_busy, core_sts.busy, !wr_en, "block store written during compression")

endmodule

// ===== tb/sha1_stream_hash_tb.sv =====
// Self-checking testbench for the streaming SHA-1 block: queued stimulus, SHA-1 predictor.
module sha1_stream_hash_tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_WORDS = 105;
  localparam int MIN_MESSAGES = 4;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] RK0 = 32'h5A827999;
  localparam logic [31:0] RK1 = 32'h6ED9EBA1;
  localparam logic [31:0] RK2 = 32'h8F1BBCDC;
  localparam logic [31:0] RK3 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_SLOT = 6'd56;

  typedef enum logic [1:0] {FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH} flow_e;

  typedef struct packed {
    flow_e            flow;
    sha1sh_pkg::msg_t m;
  } pending_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  sha1sh_pkg::msg_t    msg = '0;
  logic                msg_valid = 1'b0;
  logic                msg_ready;
  sha1sh_pkg::digest_t digest;
  logic                digest_valid;
  logic                digest_ready = 1'b0;

  pending_t            stim_q[$];
  sha1sh_pkg::digest_t digest_q[$];
  flow_e               shown_flow = FLOW_FREE;
  flow_e               cur_flow = FLOW_FREE;
  sha1sh_pkg::digest_t want;
  int unsigned cycle_count = 0;
  int unsigned words_total = 0;
  int unsigned words_taken = 0;
  int unsigned words_checked = 0;
  int unsigned messages_closed = 0;
  int unsigned double_pads = 0;
  int unsigned mismatch_count = 0;

  // predictor state
  logic [31:0] hchain [5];
  logic [31:0] hblock [16];
  logic [63:0] msg_bits;
  logic [5:0]  fill_pos;

  sha1_stream_hash uut (
    .clk(clk),
    .rst(rst),
    .msg(msg),
    .msg_valid(msg_valid),
    .msg_ready(msg_ready),
    .digest(digest),
    .digest_valid(digest_valid),
    .digest_ready(digest_ready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic int send_idle_pct(input flow_e f);
    case (f)
      FLOW_SEND_IDLE: return 60;
      FLOW_BOTH: return 17;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(input flow_e f);
    case (f)
      FLOW_RECV_STALL: return 60;
      FLOW_BOTH: return 17;
      default: return 0;
    endcase
  endfunction

  function automatic logic [31:0] rol(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void load_chain();
    hchain[0] = H0;
    hchain[1] = H1;
    hchain[2] = H2;
    hchain[3] = H3;
    hchain[4] = H4;
    msg_bits = '0;
    fill_pos = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, x, t;
    int r;
    for (r = 0; r < 16; r++) w[r] = hblock[r];
    a = hchain[0];
    b = hchain[1];
    c = hchain[2];
    d = hchain[3];
    e = hchain[4];
    for (r = 0; r < 80; r++) begin
      if (r < 16) begin
        x = w[r];
      end else begin
        // 16-entry rolling schedule
        x = rol(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16], 1);
        w[r % 16] = x;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = RK0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RK1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RK2;
      end else begin
        f = b ^ c ^ d;
        k = RK3;
      end
      t = rol(a, 5) + f + e + k + x;
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    hchain[0] = hchain[0] + a;
    hchain[1] = hchain[1] + b;
    hchain[2] = hchain[2] + c;
    hchain[3] = hchain[3] + d;
    hchain[4] = hchain[4] + e;
  endfunction

  function automatic void put_byte(input logic [7:0] v);
    int sh;
    sh = 8 * (3 - int'(fill_pos[1:0]));
    hblock[fill_pos[5:2]] = (hblock[fill_pos[5:2]] & ~(32'hFF << sh)) | ({24'b0, v} << sh);
    fill_pos = fill_pos + 6'd1;
    if (fill_pos == 6'd0) compress_block();
  endfunction

  // Advance the hash state by one accepted word; a close queues five digest words.
  function automatic void hash_word(input sha1sh_pkg::msg_t m);
    logic [63:0] len;
    logic [63:0] part;
    sha1sh_pkg::digest_t r;
    int i;
    if (m.byte_valid) begin
      msg_bits = msg_bits + 64'd8;
      put_byte(m.msg_byte);
    end
    if (m.end_of_message) begin
      len = msg_bits;
      if (fill_pos >= LEN_SLOT) double_pads++;
      put_byte(PAD_BYTE);
      while (fill_pos != LEN_SLOT) put_byte(8'h00);
      for (i = 0; i < 8; i++) begin
        part = len >> (8 * (7 - i));
        put_byte(part[7:0]);
      end
      for (i = 0; i < 5; i++) begin
        r.digest_word = hchain[i];
        r.word_index = i[2:0];
        r.digest_last = (i == 4);
        digest_q.push_back(r);
      end
      messages_closed++;
      load_chain();
    end
  endfunction

  task automatic add_word(input logic [7:0] b, input logic v, input logic eom,
                          input flow_e f);
    pending_t p;
    p.flow = f;
    p.m.msg_byte = b;
    p.m.byte_valid = v;
    p.m.end_of_message = eom;
    stim_q.push_back(p);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (msg_valid && msg_ready) begin
        hash_word(msg);
        cur_flow <= shown_flow;
        words_taken++;
      end
      if (msg_valid && !msg_ready) begin
        // hold the word until it is taken
      end else if (stim_q.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct(stim_q[0].flow)) begin
        shown_flow = stim_q[0].flow;
        msg <= stim_q[0].m;
        msg_valid <= 1'b1;
        void'(stim_q.pop_front());
      end else begin
        msg_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (digest_valid && digest_ready) begin
        words_checked++;
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h index %0d last %b", $time,
                   digest.digest_word, digest.word_index, digest.digest_last);
          mismatch_count++;
        end else begin
          want = digest_q.pop_front();
          if (digest.digest_word !== want.digest_word) begin
            $display("%0t: digest_word expected %h actual %h", $time,
                     want.digest_word, digest.digest_word);
            mismatch_count++;
          end
          if (digest.word_index !== want.word_index) begin
            $display("%0t: word_index expected %0d actual %0d", $time,
                     want.word_index, digest.word_index);
            mismatch_count++;
          end
          if (digest.digest_last !== want.digest_last) begin
            $display("%0t: digest_last expected %b actual %b", $time,
                     want.digest_last, digest.digest_last);
            mismatch_count++;
          end
        end
      end
      digest_ready <= ($urandom_range(99) >= recv_stall_pct(cur_flow));
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("%0t: timed out after %0d cycles", $time, cycle_count);
    $display("sha1_stream_hash verification failed");
    $finish;
  end

  initial begin
    int words;
    int msgs;
    int len;
    int pick;
    int i;
    bit close_last;
    flow_e flow;

    for (i = 0; i < 16; i++) hblock[i] = '0;
    load_chain();

    // directed: empty message, idle words, byte with close, close after bytes
    add_word(8'h00, 1'b0, 1'b1, FLOW_FREE);
    add_word(8'hFF, 1'b0, 1'b0, FLOW_FREE);
    add_word(8'h61, 1'b1, 1'b0, FLOW_FREE);
    add_word(8'h62, 1'b1, 1'b0, FLOW_FREE);
    add_word(8'h63, 1'b1, 1'b1, FLOW_FREE);
    add_word(8'h00, 1'b1, 1'b0, FLOW_FREE);
    add_word(8'hFF, 1'b1, 1'b0, FLOW_FREE);
    add_word(8'hFF, 1'b0, 1'b1, FLOW_FREE);
    add_word(8'h00, 1'b0, 1'b0, FLOW_FREE);
    add_word(8'h80, 1'b1, 1'b1, FLOW_FREE);
    add_word(8'hFF, 1'b1, 1'b0, FLOW_FREE);
    add_word(8'hFF, 1'b1, 1'b0, FLOW_FREE);
    add_word(8'hFF, 1'b1, 1'b0, FLOW_FREE);
    add_word(8'hFF, 1'b0, 1'b0, FLOW_FREE);
    add_word(8'hFF, 1'b1, 1'b0, FLOW_FREE);
    add_word(8'h00, 1'b1, 1'b1, FLOW_FREE);
    add_word(8'h00, 1'b0, 1'b1, FLOW_FREE);

    // random messages, mostly short, some around the block and padding boundaries
    words = 0;
    msgs = 0;
    while (words < RANDOM_WORDS || msgs < MIN_MESSAGES) begin
      flow = flow_e'(msgs % 4);
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = $urandom_range(8);
      end else if (pick < 85) begin
        case ($urandom_range(3))
          0: len = 55;
          1: len = 56;
          2: len = 63;
          default: len = 64;
        endcase
      end else begin
        len = $urandom_range(30, 9);
      end
      close_last = (len > 0) && ($urandom_range(1) == 1);
      for (i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) add_word(8'($urandom_range(255)), 1'b0, 1'b0, flow);
        add_word(8'($urandom_range(255)), 1'b1, close_last && (i == len - 1), flow);
        words++;
      end
      if (!close_last) begin
        add_word(8'($urandom_range(255)), 1'b0, 1'b1, flow);
        words++;
      end
      msgs++;
    end
    words_total = stim_q.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (words_taken < words_total || digest_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input words, %0d messages (%0d with a second pad block)",
             words_taken, messages_closed, double_pads);
    $display("checked %0d digest words under free, sender-gap, stall and mixed flow",
             words_checked);
    if (mismatch_count == 0) begin
      $display("sha1_stream_hash verification clean");
    end else begin
      $display("sha1_stream_hash verification failed");
    end
    $finish;
  end

endmodule
